/* rtl/mdl_pkg.sv */
// Shared types, widths and constants for the magnetic dipole leadfield pipeline.
`default_nettype none

package mdl_pkg;

  // Field widths
  localparam int POS_W = 20;
  localparam int ORI_W = 16;
  localparam int OUT_W = 48;

  // Datapath widths
  localparam int D_W     = POS_W + 1;     // point minus dipole
  localparam int SQ_W    = 2 * D_W;       // one squared offset (signed product)
  localparam int R2_W    = 42;            // sum of three squares
  localparam int DP_W    = D_W + ORI_W;   // one offset times orientation
  localparam int S_W     = 38;            // d.o
  localparam int P_W     = D_W + S_W;     // d_j * s
  localparam int QO_W    = R2_W + 1 + ORI_W; // r2 * o_j
  localparam int N_W     = 61;            // 3*d_j*s - r2*o_j
  localparam int M_W     = 60;            // |N_j|
  localparam int HALF_W  = R2_W / 2;      // r2 split for r2 squared
  localparam int M_LO_W  = 30;            // low part of |N_j|
  localparam int M_HI_W  = M_W - M_LO_W;
  localparam int C_LO_W  = 31;            // low part of 5^26
  localparam int C_HI_W  = 30;
  localparam int X_W     = 121;           // |N_j| * 5^26

  // Quotient chain
  localparam int DEN1_W     = 2 * R2_W;   // r2 squared
  localparam int Q2_W       = 57;         // quotient bits of the first divide
  localparam int ROOT_W     = 31;         // floor(sqrt(r2 * 2^20))
  localparam int SQX_W      = 2 * ROOT_W; // radicand width
  localparam int RAD_SHIFT  = 20;
  localparam int FRAC_SHIFT = 22;
  localparam int Q3_W       = OUT_W - 1;  // magnitude bits of a field

  // Pipeline depths
  localparam int FRONT_STAGES = 8;
  localparam int RQ_DLY       = Q2_W + 1 - ROOT_W;
  localparam int LATENCY      = FRONT_STAGES + (Q2_W + 1) + (Q3_W + 1) + 1;

  // 5^26 split into two multiplier-sized halves
  localparam logic [C_HI_W+C_LO_W-1:0] FIVE_POW26 = 61'd1490116119384765625;
  localparam logic [C_LO_W-1:0] C_LO = FIVE_POW26[C_LO_W-1:0];
  localparam logic [C_HI_W-1:0] C_HI = FIVE_POW26[C_HI_W+C_LO_W-1:C_LO_W];

  localparam logic [Q3_W-1:0] FIELD_MAX = '1;

  // Register index codes
  typedef enum logic [1:0] {
    REG_DIPOLE_X = 2'd0,
    REG_DIPOLE_Y = 2'd1,
    REG_DIPOLE_Z = 2'd2
  } reg_idx_t;

  // Fault codes
  typedef enum logic [1:0] {
    FAULT_OK   = 2'd0,
    FAULT_ZERO = 2'd1,
    FAULT_SAT  = 2'd2
  } fault_t;

  // Request payload
  typedef struct packed {
    logic signed [POS_W-1:0] point_x;
    logic signed [POS_W-1:0] point_y;
    logic signed [POS_W-1:0] point_z;
    logic signed [ORI_W-1:0] orient_x;
    logic signed [ORI_W-1:0] orient_y;
    logic signed [ORI_W-1:0] orient_z;
  } mdl_req_t;

  // Result payload
  typedef struct packed {
    logic signed [OUT_W-1:0] field_x;
    logic signed [OUT_W-1:0] field_y;
    logic signed [OUT_W-1:0] field_z;
    logic [1:0]              fault;
  } mdl_res_t;

  // Front end to divider chain
  typedef struct packed {
    logic [2:0][X_W-1:0]  num;
    logic [2:0]           neg;
    logic [DEN1_W-1:0]    den;
    logic [R2_W-1:0]      r2;
    logic                 zero;
  } mdl_front_t;

endpackage

`default_nettype wire

/* rtl/mdl_front.sv */
// Front end: offset, r2, d.o, numerators, r2 squared and scaled magnitudes.
`default_nettype none

module mdl_front
  import mdl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  mdl_req_t                req,
  input  logic signed [POS_W-1:0] dipole_x,
  input  logic signed [POS_W-1:0] dipole_y,
  input  logic signed [POS_W-1:0] dipole_z,
  output logic                    out_valid,
  output mdl_front_t              out
);

  logic [FRONT_STAGES-1:0] vld;

  logic signed [POS_W-1:0] pt  [3];
  logic signed [POS_W-1:0] dip [3];
  logic signed [ORI_W-1:0] ori [3];

  logic signed [D_W-1:0]   s1_d  [3];
  logic signed [ORI_W-1:0] s1_o  [3];
  logic signed [SQ_W-1:0]  s2_sq [3];
  logic signed [DP_W-1:0]  s2_dp [3];
  logic signed [D_W-1:0]   s2_d  [3];
  logic signed [ORI_W-1:0] s2_o  [3];
  logic [R2_W-1:0]         s3_r2;
  logic signed [S_W-1:0]   s3_s;
  logic signed [D_W-1:0]   s3_d  [3];
  logic signed [ORI_W-1:0] s3_o  [3];
  logic signed [P_W-1:0]   s4_p  [3];
  logic signed [QO_W-1:0]  s4_q  [3];
  logic [R2_W-1:0]         s4_aa;
  logic [R2_W-1:0]         s4_ab;
  logic [R2_W-1:0]         s4_bb;
  logic [R2_W-1:0]         s4_r2;
  logic signed [N_W-1:0]   s5_n  [3];
  logic [DEN1_W-1:0]       s5_den;
  logic [R2_W-1:0]         s5_r2;
  logic [M_W-1:0]          s6_m  [3];
  logic [2:0]              s6_neg;
  logic [DEN1_W-1:0]       s6_den;
  logic [R2_W-1:0]         s6_r2;
  logic [M_HI_W+C_HI_W-1:0] s7_hh [3];
  logic [M_HI_W+C_LO_W-1:0] s7_hl [3];
  logic [M_LO_W+C_HI_W-1:0] s7_lh [3];
  logic [M_LO_W+C_LO_W-1:0] s7_ll [3];
  logic [2:0]              s7_neg;
  logic [DEN1_W-1:0]       s7_den;
  logic [R2_W-1:0]         s7_r2;

  // Unpack request into per-axis arrays
  always_comb begin
    pt[0]  = req.point_x;
    pt[1]  = req.point_y;
    pt[2]  = req.point_z;
    ori[0] = req.orient_x;
    ori[1] = req.orient_y;
    ori[2] = req.orient_z;
    dip[0] = dipole_x;
    dip[1] = dipole_y;
    dip[2] = dipole_z;
  end

  // Valid bits move one stage per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld[FRONT_STAGES-1];

  // Datapath stages
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      // stage 1: offset
      s1_d[j]  <= D_W'(pt[j]) - D_W'(dip[j]);
      s1_o[j]  <= ori[j];
      // stage 2: squares and dot terms
      s2_sq[j] <= s1_d[j] * s1_d[j];
      s2_dp[j] <= s1_d[j] * s1_o[j];
      s2_d[j]  <= s1_d[j];
      s2_o[j]  <= s1_o[j];
      // stage 3: carry offsets
      s3_d[j]  <= s2_d[j];
      s3_o[j]  <= s2_o[j];
      // stage 4: numerator terms
      s4_p[j]  <= s3_d[j] * s3_s;
      s4_q[j]  <= $signed({1'b0, s3_r2}) * s3_o[j];
      // stage 5: numerator
      s5_n[j]  <= (N_W'(s4_p[j]) <<< 1) + N_W'(s4_p[j]) - N_W'(s4_q[j]);
      // stage 6: magnitude and sign
      s6_neg[j] <= s5_n[j][N_W-1];
      s6_m[j]   <= s5_n[j][N_W-1] ? M_W'(-s5_n[j]) : M_W'(s5_n[j]);
      // stage 7: partial products with 5^26
      s7_hh[j]  <= s6_m[j][M_W-1:M_LO_W] * C_HI;
      s7_hl[j]  <= s6_m[j][M_W-1:M_LO_W] * C_LO;
      s7_lh[j]  <= s6_m[j][M_LO_W-1:0] * C_HI;
      s7_ll[j]  <= s6_m[j][M_LO_W-1:0] * C_LO;
      // stage 8: scaled numerator
      out.num[j] <= (X_W'(s7_hh[j]) << (M_LO_W + C_LO_W)) + (X_W'(s7_hl[j]) << M_LO_W)
                  + (X_W'(s7_lh[j]) << C_LO_W) + X_W'(s7_ll[j]);
    end
    // stage 3: r2 and d.o
    s3_r2 <= R2_W'(s2_sq[0][SQ_W-2:0]) + R2_W'(s2_sq[1][SQ_W-2:0])
           + R2_W'(s2_sq[2][SQ_W-2:0]);
    s3_s  <= S_W'(s2_dp[0]) + S_W'(s2_dp[1]) + S_W'(s2_dp[2]);
    // stage 4: r2 squared partials
    s4_aa <= s3_r2[R2_W-1:HALF_W] * s3_r2[R2_W-1:HALF_W];
    s4_ab <= s3_r2[R2_W-1:HALF_W] * s3_r2[HALF_W-1:0];
    s4_bb <= s3_r2[HALF_W-1:0] * s3_r2[HALF_W-1:0];
    s4_r2 <= s3_r2;
    // stage 5: r2 squared
    s5_den <= {s4_aa, {R2_W{1'b0}}} + DEN1_W'({s4_ab, {(HALF_W + 1){1'b0}}})
            + DEN1_W'(s4_bb);
    s5_r2  <= s4_r2;
    s6_den <= s5_den;
    s6_r2  <= s5_r2;
    s7_neg <= s6_neg;
    s7_den <= s6_den;
    s7_r2  <= s6_r2;
    // stage 8
    out.neg  <= s7_neg;
    out.den  <= s7_den;
    out.r2   <= s7_r2;
    out.zero <= (s7_r2 == '0);
  end

endmodule

`default_nettype wire

/* rtl/mdl_sqrt.sv */
// Pipelined integer square root of r2 * 2^20, one root bit per stage.
`default_nettype none

module mdl_sqrt
  import mdl_pkg::*;
(
  input  logic              clk,
  input  logic [R2_W-1:0]   r2,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SQX_W-1:0]  rad_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [SQX_W-1:0]  rad_p;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  diff;
    logic              ge;

    // previous stage, or the radicand at the head
    if (k == 0) begin : g_head
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = SQX_W'({r2, {RAD_SHIFT{1'b0}}});
    end else begin : g_body
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rad_p  = rad_q[k-1];
    end

    // bring down two radicand bits, try 4*root+1
    always_comb begin
      cur   = {rem_p, rad_p[SQX_W-1:SQX_W-2]};
      trial = (REM_W + 2)'({root_p, 2'b01});
      ge    = cur >= trial;
      diff  = cur - trial;
    end

    always_ff @(posedge clk) begin
      rem_q[k]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
      root_q[k] <= {root_p[ROOT_W-2:0], ge};
      rad_q[k]  <= {rad_p[SQX_W-3:0], 2'b00};
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule

`default_nettype wire

/* rtl/mdl_div.sv */
// Pipelined restoring divider with overflow detect, one quotient bit per stage.
`default_nettype none

module mdl_div
  import mdl_pkg::*;
#(
  parameter int DEN_W  = DEN1_W,
  parameter int Q_W    = Q2_W,
  parameter int SIDE_W = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [DEN_W+Q_W-1:0]   num,
  input  logic [DEN_W-1:0]       den,
  input  logic [SIDE_W-1:0]      side,
  output logic                   out_valid,
  output logic [Q_W-1:0]         quo,
  output logic                   ovf,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int NUM_W = DEN_W + Q_W;

  logic              vld    [Q_W+1];
  logic              ovf_q  [Q_W+1];
  logic [DEN_W-1:0]  rem_q  [Q_W+1];
  logic [Q_W-1:0]    acc_q  [Q_W+1];
  logic [DEN_W-1:0]  den_q  [Q_W+1];
  logic [SIDE_W-1:0] side_q [Q_W+1];

  logic head_ovf;

  // Quotient would not fit in Q_W bits
  assign head_ovf = num[NUM_W-1:Q_W] >= den;

  // Head stage: overflow check, remainder seeded with the top bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ovf_q[0]  <= head_ovf;
    rem_q[0]  <= head_ovf ? '0 : num[NUM_W-1:Q_W];
    acc_q[0]  <= num[Q_W-1:0];
    den_q[0]  <= den;
    side_q[0] <= side;
  end

  // Step stages: numerator bits shift out the top, quotient bits in at the bottom
  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [DEN_W:0] cur;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb begin
      cur  = {rem_q[k-1], acc_q[k-1][Q_W-1]};
      diff = cur - {1'b0, den_q[k-1]};
      ge   = cur >= {1'b0, den_q[k-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      ovf_q[k]  <= ovf_q[k-1];
      rem_q[k]  <= ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
      acc_q[k]  <= {acc_q[k-1][Q_W-2:0], ge};
      den_q[k]  <= den_q[k-1];
      side_q[k] <= side_q[k-1];
    end
  end

  assign out_valid = vld[Q_W];
  assign quo       = acc_q[Q_W];
  assign ovf       = ovf_q[Q_W];
  assign out_side  = side_q[Q_W];

endmodule

`default_nettype wire

/* rtl/magnetic_dipole_leadfield.sv */
// Top level of the magnetic dipole leadfield pipeline: config, dividers, result register.
// Throughput: one request per cycle; busy is only high during reset.
// Depth is set by the two divide pipelines (58 and 48 stages, one quotient bit each).
// Reset clears the dipole registers to zero and drops all in-flight requests.
// The receiver cannot stall; each result is on res for the single cycle done is high.
`default_nettype none

module magnetic_dipole_leadfield
  import mdl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  mdl_req_t         req,
  output logic             done,
  output mdl_res_t         res,
  input  logic             wr_en,
  input  logic [1:0]       wr_index,
  input  logic [POS_W-1:0] wr_data
);

  localparam int DIV2_NUM_W = ROOT_W + Q3_W;

  logic signed [POS_W-1:0] dipole_x;
  logic signed [POS_W-1:0] dipole_y;
  logic signed [POS_W-1:0] dipole_z;

  logic        accept;
  logic        f_vld;
  mdl_front_t  f_out;
  logic [ROOT_W-1:0] rq;
  logic [ROOT_W-1:0] rq_dly [RQ_DLY];

  logic              v1    [3];
  logic [Q2_W-1:0]   q2    [3];
  logic              ovf1  [3];
  logic [1:0]        side1 [3];
  logic              v2    [3];
  logic [Q3_W-1:0]   q3    [3];
  logic              ovf2  [3];
  logic [2:0]        side2 [3];

  logic [OUT_W-1:0]  fld   [3];
  logic [2:0]        sat;
  logic              zero;
  mdl_res_t          res_next;

  assign busy   = rst;
  assign accept = start && !busy;

  // Dipole position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dipole_x <= '0;
      dipole_y <= '0;
      dipole_z <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_DIPOLE_X: dipole_x <= wr_data;
        REG_DIPOLE_Y: dipole_y <= wr_data;
        REG_DIPOLE_Z: dipole_z <= wr_data;
        default: ;
      endcase
    end
  end

  // Offsets, numerators, r2 squared
  mdl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .req       (req),
    .dipole_x  (dipole_x),
    .dipole_y  (dipole_y),
    .dipole_z  (dipole_z),
    .out_valid (f_vld),
    .out       (f_out)
  );

  // Distance in Q.10, runs beside the first divide
  mdl_sqrt u_sqrt (
    .clk  (clk),
    .r2   (f_out.r2),
    .root (rq)
  );

  // Line the root up with the first divide's output
  always_ff @(posedge clk) begin
    rq_dly[0] <= rq;
    for (int k = 1; k < RQ_DLY; k++) begin
      rq_dly[k] <= rq_dly[k-1];
    end
  end

  // Per-axis divide chain: by r2 squared, then by the distance
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic big;

    mdl_div #(
      .DEN_W  (DEN1_W),
      .Q_W    (Q2_W),
      .SIDE_W (2)
    ) u_div_r4 (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (f_vld),
      .num       ((DEN1_W + Q2_W)'(f_out.num[a])),
      .den       (f_out.den),
      .side      ({f_out.zero, f_out.neg[a]}),
      .out_valid (v1[a]),
      .quo       (q2[a]),
      .ovf       (ovf1[a]),
      .out_side  (side1[a])
    );

    // quotient too big for the second stage already saturates
    assign big = ovf1[a] | q2[a][Q2_W-1];

    mdl_div #(
      .DEN_W  (ROOT_W),
      .Q_W    (Q3_W),
      .SIDE_W (3)
    ) u_div_r (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v1[a]),
      .num       (DIV2_NUM_W'({q2[a][Q2_W-2:0], {FRAC_SHIFT{1'b0}}})),
      .den       (rq_dly[RQ_DLY-1]),
      .side      ({side1[a], big}),
      .out_valid (v2[a]),
      .quo       (q3[a]),
      .ovf       (ovf2[a]),
      .out_side  (side2[a])
    );
  end

  // Sign, saturation and fault code
  always_comb begin
    zero = side2[0][2] & side2[1][2] & side2[2][2];
    for (int j = 0; j < 3; j++) begin
      sat[j] = side2[j][0] | ovf2[j];
      fld[j] = {1'b0, (sat[j] ? FIELD_MAX : q3[j])};
      if (zero) begin
        fld[j] = '0;
      end else if (side2[j][1]) begin
        fld[j] = -fld[j];
      end
    end
    res_next.field_x = fld[0];
    res_next.field_y = fld[1];
    res_next.field_z = fld[2];
    if (zero) begin
      res_next.fault = FAULT_ZERO;
    end else if (|sat) begin
      res_next.fault = FAULT_SAT;
    end else begin
      res_next.fault = FAULT_OK;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2[0] & v2[1] & v2[2];
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  // Every result traces back to a request a fixed latency earlier
  a_done_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without matching request");

  // Every request produces its result after the fixed latency
  a_req_gives_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("request lost in pipeline");

  // Point on the dipole gives zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    done && (res.fault == FAULT_ZERO) |->
      (res.field_x == '0) && (res.field_y == '0) && (res.field_z == '0))
    else $error("nonzero field on coincident point");

  // Distance is nonzero whenever r2 is nonzero
  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    f_vld && !f_out.zero |-> ##ROOT_W (rq != '0))
    else $error("zero distance for nonzero r2");

endmodule

`default_nettype wire
